/* rtl/ocf_pkg.sv */
// Package for the overlap classify and finalize unit.
// Holds the beat structs, the overlap kind codes and the internal-test constant.
// No dependencies.
`default_nettype none

package ocf_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned KindBits  = 3;

  // An overlap is internal when span < 7 * overhang (7 = 8 * 0.875 = 2^SpanFactorShift - 1).
  localparam int unsigned SpanFactorShift = 3;
  localparam int unsigned ProdBits        = CoordBits + SpanFactorShift;

  typedef logic [CoordBits-1:0] coord_t;

  typedef enum logic [KindBits-1:0] {
    KindInternal     = 3'd0,
    KindLeftContain  = 3'd1,
    KindRightContain = 3'd2,
    KindLeftToRight  = 3'd3,
    KindRightToLeft  = 3'd4
  } kind_e;

  typedef struct packed {
    coord_t left_start;
    coord_t left_stop;
    coord_t right_start;
    coord_t right_stop;
    logic   same_strand;
    coord_t left_region_start;
    coord_t left_region_stop;
    coord_t right_region_start;
    coord_t right_region_stop;
    coord_t right_read_length;
  } ocf_in_t;

  typedef struct packed {
    logic [KindBits-1:0] overlap_kind;
    logic                accepted;
    coord_t              out_left_start;
    coord_t              out_left_stop;
    coord_t              out_right_start;
    coord_t              out_right_stop;
  } ocf_out_t;

  // Region-relative coordinates, computed in the first stage.
  typedef struct packed {
    coord_t lb;
    coord_t le;
    coord_t ltail;
    coord_t rb;
    coord_t re;
    coord_t rtail;
    coord_t lspan;
    coord_t rspan;
    coord_t rrel_b;
    coord_t rrel_e;
    coord_t rlen_read;
    coord_t ls;
    coord_t lt;
    coord_t rs;
    coord_t rt;
    logic   same;
  } ocf_prep_t;

endpackage

`default_nettype wire

/* rtl/overlap_classify_finalize_unit.sv */
// Top level of the overlap classify and finalize unit: a two-stage pipeline.
// Depends on ocf_pkg, ocf_prep and ocf_classify.
//
//   Channel   Direction  Handshake               Payload
//   in        input      in_valid_i / in_ready_o    in_beat_i  (ocf_in_t)
//   out       output     out_valid_o / out_ready_i  out_beat_o (ocf_out_t)
//
// One beat enters per cycle while the output is not stalled; each taken beat passes
// through the two pipeline registers (relative coordinates, then the result).
// Reset empties both stages; payload registers are not reset.
// When the output stalls, a beat still moves into any empty stage, so the
// unit takes new beats until both stages are full.
// in_ready_o depends combinationally on out_ready_i through the stage chain.
`default_nettype none

module overlap_classify_finalize_unit
  import ocf_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire ocf_in_t in_beat_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output ocf_out_t     out_beat_o
);

  ocf_prep_t prep_d;
  ocf_prep_t prep_q;
  logic      s1_valid_q;
  ocf_out_t  res_d;
  ocf_out_t  res_q;
  logic      s2_valid_q;
  logic      s1_ready;
  logic      s2_ready;

  // Stage 1 logic: subtract the region starts, mirror on the reverse strand.
  ocf_prep u_prep (
    .beat_i (in_beat_i),
    .prep_o (prep_d)
  );

  // Stage 2 logic: classify the overlap and pick the output coordinates.
  ocf_classify u_classify (
    .prep_i (prep_q),
    .beat_o (res_d)
  );

  // A stage can load when it is empty or its contents move on this cycle.
  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers load only when a beat actually moves in.
  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      prep_q <= prep_d;
    end
    if (s2_ready && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_beat_o  = res_q;

`ifndef SYNTHESIS
  // A beat taken at the input is held in stage 1 on the next cycle.
  a_in_to_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted input beat did not reach stage 1");

  // A stage 1 beat that can advance shows up at the output next cycle.
  a_s1_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> out_valid_o)
    else $error("stage 1 beat lost on its way to the output");

  // An empty first stage never stalls the input.
  a_bubble_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled while stage 1 is empty");
`endif

endmodule

`default_nettype wire

/* rtl/ocf_prep.sv */
// First stage logic: region-relative coordinates, tails and spans.
// Depends on ocf_pkg.
`default_nettype none

module ocf_prep
  import ocf_pkg::*;
(
  input  wire ocf_in_t beat_i,
  output ocf_prep_t    prep_o
);

  // Every computed value below reduces to a single modular subtraction of two inputs.
  // On the reverse strand the right interval is mirrored against the region
  // length, which cancels the region start against itself.
  always_comb begin
    prep_o.ls        = beat_i.left_start;
    prep_o.lt        = beat_i.left_stop;
    prep_o.rs        = beat_i.right_start;
    prep_o.rt        = beat_i.right_stop;
    prep_o.same      = beat_i.same_strand;
    prep_o.rlen_read = beat_i.right_read_length;

    prep_o.lb     = beat_i.left_start - beat_i.left_region_start;
    prep_o.le     = beat_i.left_stop - beat_i.left_region_start;
    prep_o.ltail  = beat_i.left_region_stop - beat_i.left_stop;
    prep_o.lspan  = beat_i.left_stop - beat_i.left_start;
    prep_o.rspan  = beat_i.right_stop - beat_i.right_start;
    prep_o.rrel_b = beat_i.right_start - beat_i.right_region_start;
    prep_o.rrel_e = beat_i.right_stop - beat_i.right_region_start;

    if (beat_i.same_strand) begin
      prep_o.rb    = beat_i.right_start - beat_i.right_region_start;
      prep_o.re    = beat_i.right_stop - beat_i.right_region_start;
      prep_o.rtail = beat_i.right_region_stop - beat_i.right_stop;
    end else begin
      prep_o.rb    = beat_i.right_region_stop - beat_i.right_stop;
      prep_o.re    = beat_i.right_region_stop - beat_i.right_start;
      prep_o.rtail = beat_i.right_start - beat_i.right_region_start;
    end
  end

endmodule

`default_nettype wire

/* rtl/ocf_classify.sv */
// Second stage logic: overlap classification and coordinate rewrite.
// Depends on ocf_pkg.
`default_nettype none

module ocf_classify
  import ocf_pkg::*;
(
  input  wire ocf_prep_t prep_i,
  output ocf_out_t       beat_o
);

  coord_t             min_start;
  coord_t             min_tail;
  coord_t             overhang;
  logic [ProdBits-1:0] overhang_x7;
  logic               short_l;
  logic               short_r;
  kind_e              kind;
  logic               acc;

  always_comb begin
    min_start = (prep_i.lb < prep_i.rb) ? prep_i.lb : prep_i.rb;
    min_tail  = (prep_i.ltail < prep_i.rtail) ? prep_i.ltail : prep_i.rtail;
    overhang  = min_start + min_tail;

    // 7 * overhang as 8 * overhang - overhang, wide enough not to wrap.
    overhang_x7 = {overhang, {SpanFactorShift{1'b0}}}
                - {{SpanFactorShift{1'b0}}, overhang};
    short_l = {{SpanFactorShift{1'b0}}, prep_i.lspan} < overhang_x7;
    short_r = {{SpanFactorShift{1'b0}}, prep_i.rspan} < overhang_x7;

    if (short_l || short_r) begin
      kind = KindInternal;
    end else if ((prep_i.lb <= prep_i.rb) && (prep_i.ltail <= prep_i.rtail)) begin
      kind = KindLeftContain;
    end else if ((prep_i.rb <= prep_i.lb) && (prep_i.rtail <= prep_i.ltail)) begin
      kind = KindRightContain;
    end else if (prep_i.lb > prep_i.rb) begin
      kind = KindLeftToRight;
    end else begin
      kind = KindRightToLeft;
    end

    acc = (kind == KindLeftToRight) || (kind == KindRightToLeft);

    beat_o.overlap_kind = kind;
    beat_o.accepted     = acc;
    if (acc) begin
      beat_o.out_left_start = prep_i.lb;
      beat_o.out_left_stop  = prep_i.le;
      if (prep_i.same) begin
        beat_o.out_right_start = prep_i.rrel_b;
        beat_o.out_right_stop  = prep_i.rrel_e;
      end else begin
        beat_o.out_right_start = prep_i.rlen_read - prep_i.rrel_e;
        beat_o.out_right_stop  = prep_i.rlen_read - prep_i.rrel_b;
      end
    end else begin
      beat_o.out_left_start  = prep_i.ls;
      beat_o.out_left_stop   = prep_i.lt;
      beat_o.out_right_start = prep_i.rs;
      beat_o.out_right_stop  = prep_i.rt;
    end
  end

endmodule

`default_nettype wire

/* sim/tb_overlap_classify_finalize_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for overlap_classify_finalize_unit: random and directed overlap
// records with random idling on both channels. Depends on ocf_pkg and the unit's RTL only.

import ocf_pkg::*;

// Holds the predicted results in beat order and compares the unit's results against them.
class overlap_scoreboard;
  // The 0.875 test is span < 7 * overhang, i.e. overhang > span / 7.
  localparam coord_t InternalSpanFactor = (1 << SpanFactorShift) - 1;

  ocf_out_t    predicted[$];
  int unsigned failures = 0;

  function bit span_is_short(coord_t span, coord_t overhang);
    return overhang > span / InternalSpanFactor;
  endfunction

  function ocf_out_t finalize_overlap(ocf_in_t beat);
    coord_t   lb, le, llen, rrel_b, rrel_e, rlen, rb, re, ltail, rtail, overhang;
    kind_e    kind;
    ocf_out_t res;
    lb     = beat.left_start - beat.left_region_start;
    le     = beat.left_stop - beat.left_region_start;
    llen   = beat.left_region_stop - beat.left_region_start;
    rrel_b = beat.right_start - beat.right_region_start;
    rrel_e = beat.right_stop - beat.right_region_start;
    rlen   = beat.right_region_stop - beat.right_region_start;
    // On the reverse strand the right interval is seen mirrored inside its region.
    rb     = beat.same_strand ? rrel_b : coord_t'(rlen - rrel_e);
    re     = beat.same_strand ? rrel_e : coord_t'(rlen - rrel_b);
    ltail  = llen - le;
    rtail  = rlen - re;
    overhang = ((lb < rb) ? lb : rb) + ((ltail < rtail) ? ltail : rtail);
    if (span_is_short(le - lb, overhang) || span_is_short(re - rb, overhang)) begin
      kind = KindInternal;
    end else if (lb <= rb && ltail <= rtail) begin
      kind = KindLeftContain;
    end else if (rb <= lb && rtail <= ltail) begin
      kind = KindRightContain;
    end else if (lb > rb) begin
      kind = KindLeftToRight;
    end else begin
      kind = KindRightToLeft;
    end
    res.overlap_kind    = kind;
    res.accepted        = (kind == KindLeftToRight) || (kind == KindRightToLeft);
    res.out_left_start  = beat.left_start;
    res.out_left_stop   = beat.left_stop;
    res.out_right_start = beat.right_start;
    res.out_right_stop  = beat.right_stop;
    if (res.accepted) begin
      res.out_left_start  = lb;
      res.out_left_stop   = le;
      res.out_right_start = beat.same_strand ? rrel_b
                                             : coord_t'(beat.right_read_length - rrel_e);
      res.out_right_stop  = beat.same_strand ? rrel_e
                                             : coord_t'(beat.right_read_length - rrel_b);
    end
    return res;
  endfunction

  function void report(string msg);
    $display("%0t: %s", $time, msg);
  endfunction

  function void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      failures++;
      report($sformatf("%s mismatch: expected %h, got %h", field, want, got));
    end
  endfunction

  function void note_input(ocf_in_t beat);
    predicted.push_back(finalize_overlap(beat));
  endfunction

  function int unsigned outstanding();
    return predicted.size();
  endfunction

  function void check_result(ocf_out_t got);
    ocf_out_t want;
    if (predicted.size() == 0) begin
      failures++;
      report($sformatf("result beat with nothing pending: expected none, got %h", got));
      return;
    end
    want = predicted[0];
    predicted.delete(0);
    compare_field("overlap_kind", 32'(want.overlap_kind), 32'(got.overlap_kind));
    compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
    compare_field("out_left_start", want.out_left_start, got.out_left_start);
    compare_field("out_left_stop", want.out_left_stop, got.out_left_stop);
    compare_field("out_right_start", want.out_right_start, got.out_right_start);
    compare_field("out_right_stop", want.out_right_stop, got.out_right_stop);
  endfunction
endclass

module tb_overlap_classify_finalize_unit;

  // Random beats per idling phase; four phases give about 1200 random beats.
  localparam int unsigned BeatsPerPhase = 300;
  // Cycles the receiver holds off once, long enough to fill both pipeline stages.
  localparam int unsigned HoldOffCycles = 64;
  // Cycles allowed after the last result.
  localparam int unsigned TailCycles = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ocf_in_t  in_beat_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ocf_out_t out_beat_o;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // Remaining cycles of a forced receiver hold-off; counted down by the receiver process.
  int unsigned hold_cycles = 0;

  overlap_scoreboard overlap_results = new();

  overlap_classify_finalize_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_beat_o (out_beat_o)
  );

  always #5 clk_i = ~clk_i;

  // Both channels are observed at the rising edge, before the unit's registers update.
  // Every accepted input beat gets its prediction queued, and every accepted result
  // beat is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        overlap_results.note_input(in_beat_i);
      end
      if (out_valid_o && out_ready_i) begin
        overlap_results.check_result(out_beat_o);
      end
    end
  end

  // Fills every coordinate with one pattern; used for the extreme and bit-pattern beats.
  function automatic ocf_in_t fill_beat(coord_t value, logic same);
    ocf_in_t beat;
    beat.left_start         = value;
    beat.left_stop          = value;
    beat.right_start        = value;
    beat.right_stop         = value;
    beat.same_strand        = same;
    beat.left_region_start  = value;
    beat.left_region_stop   = value;
    beat.right_region_start = value;
    beat.right_region_stop  = value;
    beat.right_read_length  = value;
    return beat;
  endfunction

  // Builds a record from region-relative geometry: each read is hang, span, tail inside its
  // region. For the reverse strand the right interval is placed so that, once mirrored,
  // it shows the given hang and tail.
  function automatic ocf_in_t make_record(coord_t lrs, coord_t lhang, coord_t lspan,
                                          coord_t ltail, coord_t rrs, coord_t rhang,
                                          coord_t rspan, coord_t rtail, logic same,
                                          coord_t read_extra);
    ocf_in_t beat;
    coord_t  rlen;
    rlen                    = rhang + rspan + rtail;
    beat.same_strand        = same;
    beat.left_region_start  = lrs;
    beat.left_start         = lrs + lhang;
    beat.left_stop          = lrs + lhang + lspan;
    beat.left_region_stop   = lrs + lhang + lspan + ltail;
    beat.right_region_start = rrs;
    beat.right_region_stop  = rrs + rlen;
    beat.right_start        = rrs + (same ? rhang : rtail);
    beat.right_stop         = rrs + (same ? rhang : rtail) + rspan;
    beat.right_read_length  = rrs + rlen + read_extra;
    return beat;
  endfunction

  // Overhangs are mostly short so that contained and dovetail overlaps come up often;
  // the longer ones drive the internal test, and a few are arbitrary.
  function automatic coord_t pick_hang();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      return $urandom_range(0, 20);
    end else if (pick < 9) begin
      return $urandom_range(21, 5000);
    end
    return $urandom;
  endfunction

  // Region starts near zero most of the time, anywhere (and so wrapping) otherwise.
  function automatic coord_t pick_region_start();
    if ($urandom_range(0, 4) == 0) begin
      return $urandom;
    end
    return $urandom_range(0, 100000);
  endfunction

  function automatic ocf_in_t well_formed_record();
    coord_t span;
    coord_t extra;
    span  = $urandom_range(1, 20000);
    extra = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 1000);
    return make_record(pick_region_start(), pick_hang(), span, pick_hang(),
                       pick_region_start(), pick_hang(), span + $urandom_range(0, 100),
                       pick_hang(), 1'($urandom_range(0, 1)), extra);
  endfunction

  function automatic ocf_in_t noise_record();
    ocf_in_t beat;
    beat.left_start         = $urandom;
    beat.left_stop          = $urandom;
    beat.right_start        = $urandom;
    beat.right_stop         = $urandom;
    beat.same_strand        = 1'($urandom_range(0, 1));
    beat.left_region_start  = $urandom;
    beat.left_region_stop   = $urandom;
    beat.right_region_start = $urandom;
    beat.right_region_stop  = $urandom;
    beat.right_read_length  = $urandom;
    return beat;
  endfunction

  // Mostly well-formed overlaps, a quarter pure noise and some damaged records.
  function automatic ocf_in_t random_record();
    ocf_in_t     beat;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) begin
      return noise_record();
    end
    beat = well_formed_record();
    if (pick < 8) begin
      case ($urandom_range(0, 4))
        0: beat.left_start = $urandom;
        1: {beat.left_start, beat.left_stop} = {beat.left_stop, beat.left_start};
        2: beat.right_stop = beat.right_start - $urandom_range(1, 50);
        3: beat.same_strand = ~beat.same_strand;
        default: beat.right_region_stop = $urandom;
      endcase
    end
    return beat;
  endfunction

  // Offers one beat, called at a falling edge. Random idle cycles come first, with junk
  // on the payload while valid is low; then the beat is held until the unit takes it.
  // Returns at the falling edge after the accepting edge, with valid still high, so a
  // following beat can go out back to back.
  task automatic send_beat(ocf_in_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_beat_i  <= noise_record();
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (overlap_results.outstanding() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Receiver: a fresh ready decision every cycle, or a forced hold-off while one is
  // requested. Ready stays low through reset.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Main sequence: reset, directed records, then four phases of random records with
  // different idling on each side.
  initial begin
    int unsigned idle_table[4];
    int unsigned stall_table[4];
    ocf_in_t     beat;
    int unsigned phase;
    int unsigned n;

    idle_table  = '{0, 51, 0, 34};
    stall_table = '{0, 0, 51, 34};

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes and alternating bit patterns on every field.
    send_beat(fill_beat('0, 1'b0));
    send_beat(fill_beat('1, 1'b1));
    send_beat(fill_beat(32'hAAAA_AAAA, 1'b0));
    send_beat(fill_beat(32'h5555_5555, 1'b1));
    // Left read contained, then right read contained.
    send_beat(make_record(100, 0, 1000, 0, 200, 50, 1000, 50, 1'b1, 0));
    send_beat(make_record(100, 50, 1000, 50, 200, 0, 1000, 0, 1'b1, 0));
    // Dovetails in both directions, on both strands.
    send_beat(make_record(100, 500, 1000, 0, 200, 0, 1000, 500, 1'b1, 10));
    send_beat(make_record(100, 0, 1000, 500, 200, 500, 1000, 0, 1'b1, 10));
    send_beat(make_record(100, 500, 1000, 0, 200, 0, 1000, 500, 1'b0, 10));
    send_beat(make_record(100, 0, 1000, 500, 200, 500, 1000, 0, 1'b0, 10));
    // Internal: overhang far too long for the spans.
    send_beat(make_record(100, 500, 1000, 500, 200, 500, 1000, 500, 1'b1, 0));
    // The 0.875 boundary: span of exactly seven overhangs passes, one less is internal.
    send_beat(make_record(0, 10, 70, 5, 0, 20, 70, 0, 1'b1, 0));
    send_beat(make_record(0, 10, 69, 5, 0, 20, 69, 0, 1'b1, 0));
    // Regions that wrap past the top of the coordinate space.
    send_beat(make_record(32'hFFFF_FF00, 400, 1000, 0, 32'hFFFF_FFF0, 0, 1000, 400, 1'b0, 0));
    // Overhang sum that wraps to zero.
    send_beat(make_record(0, 32'h8000_0000, 16, 32'h8000_0000,
                          0, 32'h8000_0000, 16, 32'h8000_0000, 1'b1, 0));
    // Reverse strand accepted with a read length shorter than the mirrored interval.
    beat = make_record(5000, 500, 1000, 0, 7000, 0, 1000, 500, 1'b0, 0);
    beat.right_read_length = 32'd10;
    send_beat(beat);
    // Reverse strand accepted with the largest read length.
    beat.right_read_length = '1;
    send_beat(beat);
    // Coordinates below the region start.
    beat = make_record(5000, 0, 1000, 500, 7000, 500, 1000, 0, 1'b1, 0);
    beat.left_start = beat.left_region_start - 5;
    send_beat(beat);
    wait_until_drained();

    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_table[phase];
      recv_stall_pct = stall_table[phase];
      for (n = 0; n < BeatsPerPhase; n++) begin
        // Once, with the sender at full rate, the receiver holds off long enough for
        // both stages to fill and the input to stall.
        if (phase == 0 && n == BeatsPerPhase / 2) begin
          hold_cycles = HoldOffCycles;
        end
        send_beat(random_record());
      end
      // The sender pauses here until every result of the phase has come back.
      wait_until_drained();
    end

    // Let any stray result beat show up before the verdict.
    repeat (TailCycles) @(negedge clk_i);
    if (overlap_results.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: ends a run that never finishes and reports it as failed.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* overlap_classify_finalize_unit.f */
rtl/ocf_pkg.sv
rtl/ocf_prep.sv
rtl/ocf_classify.sv
rtl/overlap_classify_finalize_unit.sv
sim/tb_overlap_classify_finalize_unit.sv
